>>> design/hne_pkg.sv
// ----------------------------------------------------------------------------
// hne_pkg: shared types and codes of the n-gram encoder
// Command codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package hne_pkg;

  // Command codes of an input word
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

`default_nettype wire

>>> design/hdc_ngram_encoder.sv
// ----------------------------------------------------------------------------
// hdc_ngram_encoder: hyperdimensional n-gram encoder
// Counts item vector bits per dimension, thresholds each frame, folds frames
// by rotate and xor, and streams the n-gram hypervector out in 64-bit slices.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per handshake.
//   A load word writes one 64-bit item memory slice; loads can follow each
//   other in every cycle while no encode word runs. An encode word walks the
//   item memory row of its (level, feature) pair one slice per cycle, unless
//   the output stalls, through a two-stage read/modify/write loop over the
//   counter and accumulator memories, so it holds in_ready_o low until its
//   last slice is written back; the next word is taken after that.
//   Out-of-range words are taken and change nothing.
//   The encode word of feature FEATURES-1 closes a frame; on the NGRAM-th
//   frame each slice is emitted on the output channel as it is folded,
//   passing the read registers and then the output register.
//   A stalled receiver holds the output register and freezes the slice loop
//   until the word is taken; the last slice may still wait while new words
//   are accepted.
//   Reset clears counters and accumulator at once through per-row valid
//   bits; the item memory is undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_ngram_encoder #(
  parameter int DIMENSION = 1024,
  parameter int FEATURES  = 32,
  parameter int LEVELS    = 16,
  parameter int NGRAM     = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [4:0]  feature_i,
  input  wire logic [3:0]  level_i,
  input  wire logic [3:0]  slice_index_i,
  input  wire logic [63:0] load_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      hv_slice_o,
  output logic [3:0]       out_slice_index_o,
  output logic             last_slice_o
);

  localparam int NSLICES   = DIMENSION / 64;
  localparam int MEM_WORDS = LEVELS * FEATURES * NSLICES;
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SW        = (NSLICES > 1) ? $clog2(NSLICES) : 1;
  localparam int THR       = FEATURES / 2;
  localparam int CW        = $clog2(THR + 2);
  localparam int PW        = $clog2(NGRAM + 1);

  // Memories
  logic [63:0]      item_mem [MEM_WORDS];
  logic [64*CW-1:0] cnt_mem  [NSLICES];
  logic [63:0]      acc_mem  [NSLICES];

  logic [NSLICES-1:0] cnt_vld_q, acc_vld_q;

  hne_pkg::state_e state_q, state_d;
  logic [AW-1:0]   base_q;
  logic            close_q, emit_q;
  logic [PW-1:0]   pos_q;
  logic [SW-1:0]   a_slice_q, b_slice_q;
  logic            a_act_q, b_vld_q;
  logic            top_q, prev_top_q;

  logic [63:0]      item_rd_q, acc_rd_q;
  logic [64*CW-1:0] cnt_rd_q;

  logic            out_vld_q;
  logic [63:0]     out_hv_q;
  logic [3:0]      out_idx_q;
  logic            out_last_q;

  logic in_range, load_ok, accept, start, stall, advance, b_fire, b_done;
  logic [AW-1:0] in_addr;

  // Decode the input word
  assign in_range = (32'(feature_i) < FEATURES) && (32'(level_i) < LEVELS);
  assign load_ok  = in_range && (32'(slice_index_i) < NSLICES);
  assign in_addr  = AW'((32'(level_i) * FEATURES + 32'(feature_i)) * NSLICES);
  assign accept   = in_valid_i && in_ready_o;
  assign start    = accept && in_range && (command_i == hne_pkg::CMD_ENCODE);

  // Freeze the slice loop while an emitted slice cannot be placed
  assign stall   = b_vld_q && emit_q && out_vld_q && !out_ready_i;
  assign advance = !stall;
  assign b_fire  = b_vld_q && advance;
  assign b_done  = b_fire && (b_slice_q == SW'(NSLICES - 1));

  // Next state
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      hne_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (start) state_d = hne_pkg::ST_RUN;
      end
      hne_pkg::ST_RUN: begin
        if (b_done) state_d = hne_pkg::ST_IDLE;
      end
      default: state_d = hne_pkg::ST_IDLE;
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hne_pkg::ST_IDLE;
      a_act_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      a_slice_q <= '0;
      b_slice_q <= '0;
      pos_q     <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        a_act_q   <= 1'b1;
        a_slice_q <= '0;
      end else if (advance) begin
        b_vld_q   <= a_act_q;
        b_slice_q <= a_slice_q;
        if (a_act_q) begin
          a_slice_q <= a_slice_q + SW'(1);
          if (a_slice_q == SW'(NSLICES - 1)) a_act_q <= 1'b0;
        end
      end
      if (b_done && close_q) begin
        pos_q <= emit_q ? '0 : pos_q + PW'(1);
      end
    end
  end

  // Latch the encode word
  always_ff @(posedge clk_i) begin
    if (start) begin
      base_q  <= in_addr;
      close_q <= (32'(feature_i) == FEATURES - 1);
      emit_q  <= (32'(feature_i) == FEATURES - 1) && (32'(pos_q) == NGRAM - 1);
    end
  end

  // Item memory: load writes, encode reads it with the counter and accumulator rows
  always_ff @(posedge clk_i) begin
    if (accept && load_ok && (command_i == hne_pkg::CMD_LOAD)) begin
      item_mem[in_addr + AW'(slice_index_i)] <= load_data_i;
    end
    if (advance && a_act_q) begin
      item_rd_q <= item_mem[base_q + AW'(a_slice_q)];
      cnt_rd_q  <= cnt_mem[a_slice_q];
      acc_rd_q  <= acc_mem[a_slice_q];
    end
  end

  // Count lanes and form the frame bits
  logic [64*CW-1:0] cnt_old, cnt_new;
  logic [63:0]      frame, acc_old, acc_new;
  logic             carry;

  always_comb begin
    cnt_old = cnt_vld_q[b_slice_q] ? cnt_rd_q : '0;
    acc_old = acc_vld_q[b_slice_q] ? acc_rd_q : '0;
    for (int i = 0; i < 64; i++) begin
      if (32'(cnt_old[i*CW +: CW]) >= THR) begin
        cnt_new[i*CW +: CW] = cnt_old[i*CW +: CW];
      end else begin
        cnt_new[i*CW +: CW] = cnt_old[i*CW +: CW] + CW'(item_rd_q[i]);
      end
      frame[i] = (32'(cnt_new[i*CW +: CW]) >= THR);
    end
    carry   = (b_slice_q == '0) ? top_q : prev_top_q;
    acc_new = {acc_old[62:0], carry} ^ frame;
  end

  // Write back counters and accumulator
  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      if (!close_q) cnt_mem[b_slice_q] <= cnt_new;
      if (close_q)  acc_mem[b_slice_q] <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      acc_vld_q  <= '0;
      top_q      <= 1'b0;
      prev_top_q <= 1'b0;
    end else if (b_fire) begin
      prev_top_q             <= acc_old[63];
      cnt_vld_q[b_slice_q]   <= !close_q;
      if (close_q) begin
        acc_vld_q[b_slice_q] <= !emit_q;
        if (b_slice_q == SW'(NSLICES - 1)) top_q <= emit_q ? 1'b0 : acc_new[63];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_fire && emit_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && emit_q) begin
      out_hv_q   <= acc_new;
      out_idx_q  <= 4'(b_slice_q);
      out_last_q <= (b_slice_q == SW'(NSLICES - 1));
    end
  end

  assign out_valid_o       = out_vld_q;
  assign hv_slice_o        = out_hv_q;
  assign out_slice_index_o = out_idx_q;
  assign last_slice_o      = out_last_q;

endmodule

`default_nettype wire

>>> design/hne_checker.sv
// ----------------------------------------------------------------------------
// hne_checker: port-level checks of the n-gram encoder
// Watches the output stream and its tie to input flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module hne_checker #(
  parameter int DIMENSION = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] hv_slice_o,
  input wire logic [3:0]  out_slice_index_o,
  input wire logic        last_slice_o
);

  localparam int NSLICES = DIMENSION / 64;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hv_slice_o))
    else $error("stalled output word changed");

  // Flag the last slice at the final position only
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_slice_o |-> out_slice_index_o == 4'(NSLICES - 1))
    else $error("last slice at wrong position");

  // Keep input blocked while later slices remain to be emitted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_slice_o |-> !in_ready_o)
    else $error("input taken during hypervector output");

endmodule

bind hdc_ngram_encoder hne_checker #(
  .DIMENSION(DIMENSION)
) u_hne_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hyperdimensional n-gram encoder
// Loads the item memory, then sends directed and random encode and load words with
// random idling on both channels. A behavioral model predicts every emitted
// hypervector slice, and the monitor compares each slice in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFEAT    = 32;
  localparam int NLVL     = 16;
  localparam int NSL      = 16;
  localparam int NGRAM_N  = 4;
  localparam int THRESH   = NFEAT / 2;
  localparam int CNT_SAT  = 65535;
  localparam int N_RANDOM = 400;
  localparam int N_USED   = 4;
  localparam int STALL_LIM = 4000;
  localparam int HOLD_LEN = 300;
  localparam logic [63:0] ONES = '1;

  typedef struct {
    logic        cmd;
    logic [4:0]  feat;
    logic [3:0]  lvl;
    logic [3:0]  sl;
    logic [63:0] data;
  } word_t;

  typedef struct {
    logic [63:0] hv;
    logic [3:0]  idx;
    logic        last;
  } slice_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = hne_pkg::CMD_LOAD;
  logic [4:0]  feature_i = '0;
  logic [3:0]  level_i = '0;
  logic [3:0]  slice_index_i = '0;
  logic [63:0] load_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] hv_slice_o;
  logic [3:0]  out_slice_index_o;
  logic        last_slice_o;

  hdc_ngram_encoder u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .feature_i,
    .level_i, .slice_index_i, .load_data_i, .out_valid_o, .out_ready_i,
    .hv_slice_o, .out_slice_index_o, .last_slice_o
  );

  // Features whose rows get loaded; the last one closes frames
  int          used_feat [N_USED] = '{0, 5, 16, 31};

  // Model state
  logic [63:0] item_mem [NLVL][NFEAT][NSL];
  bit          item_written [NLVL][NFEAT][NSL];
  int          ones_cnt [NSL*64];
  logic [63:0] ngram_acc [NSL];
  int          frames_done;
  slice_t      hv_expected [$];

  int  mismatches;
  int  quiet_cycles;
  bit  calm;          // no idling on either side
  bit  hold_request;  // ask the receiver for one long hold-off
  bit  running;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Report one mismatch
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic bit row_ready(int lvl, int feat);
    for (int s = 0; s < NSL; s++) begin
      if (!item_written[lvl][feat][s]) return 0;
    end
    return 1;
  endfunction

  // Fold a closed frame into the n-gram and emit it on the last frame
  function automatic void close_frame();
    logic [63:0] frame_w [NSL];
    logic [63:0] rot_w [NSL];
    slice_t      sl;
    for (int s = 0; s < NSL; s++) begin
      for (int b = 0; b < 64; b++) frame_w[s][b] = ones_cnt[s*64+b] >= THRESH;
      rot_w[s] = {ngram_acc[s][62:0], ngram_acc[(s+NSL-1)%NSL][63]};
    end
    for (int s = 0; s < NSL; s++) ngram_acc[s] = rot_w[s] ^ frame_w[s];
    foreach (ones_cnt[d]) ones_cnt[d] = 0;
    frames_done++;
    if (frames_done == NGRAM_N) begin
      for (int s = 0; s < NSL; s++) begin
        sl.hv   = ngram_acc[s];
        sl.idx  = 4'(s);
        sl.last = (s == NSL-1);
        hv_expected.push_back(sl);
        ngram_acc[s] = '0;
      end
      frames_done = 0;
    end
  endfunction

  // Apply one accepted word to the model
  function automatic void encode_word(word_t w);
    if (w.cmd == hne_pkg::CMD_LOAD) begin
      item_mem[w.lvl][w.feat][w.sl] = w.data;
      item_written[w.lvl][w.feat][w.sl] = 1;
      return;
    end
    for (int s = 0; s < NSL; s++) begin
      for (int b = 0; b < 64; b++) begin
        if (item_mem[w.lvl][w.feat][s][b] && ones_cnt[s*64+b] < CNT_SAT)
          ones_cnt[s*64+b]++;
      end
    end
    if (w.feat == 5'(NFEAT-1)) close_frame();
  endfunction

  // Offer one word; hold it until the handshake
  task automatic send_word(word_t w);
    while (!calm && $urandom_range(99) < 9) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= w.cmd;
    feature_i     <= w.feat;
    level_i       <= w.lvl;
    slice_index_i <= w.sl;
    load_data_i   <= w.data;
    do @(posedge clk_i); while (!in_ready_o);
    encode_word(w);
  endtask

  function automatic word_t mk(logic cmd, int feat, int lvl, int sl, logic [63:0] d);
    word_t w;
    w.cmd = cmd; w.feat = 5'(feat); w.lvl = 4'(lvl); w.sl = 4'(sl); w.data = d;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a level whose row is fully loaded for this feature
  function automatic int pick_level(int feat);
    int lvl;
    for (int t = 0; t < 8; t++) begin
      lvl = $urandom_range(NLVL-1);
      if (row_ready(lvl, feat)) return lvl;
    end
    return feat % NLVL;
  endfunction

  // Receiver: random stalls plus one long hold-off once a slice waits
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done && out_valid_o) begin
        hold_left = HOLD_LEN;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Compare each emitted slice with the oldest prediction
  always @(posedge clk_i) begin
    slice_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hv_expected.size() == 0) begin
        report("unexpected slice", hv_slice_o, '0);
      end else begin
        want = hv_expected.pop_front();
        if (hv_slice_o !== want.hv) report("hv_slice", hv_slice_o, want.hv);
        if (out_slice_index_o !== want.idx)
          report("out_slice_index", 64'(out_slice_index_o), 64'(want.idx));
        if (last_slice_o !== want.last)
          report("last_slice", 64'(last_slice_o), 64'(want.last));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (running) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIM) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIM);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Directed words, sent once every used row is loaded
  word_t directed [] = '{
    mk(hne_pkg::CMD_LOAD,   31, 15, 15, ONES),
    mk(hne_pkg::CMD_LOAD,   31, 15,  0, ONES),
    mk(hne_pkg::CMD_LOAD,    0,  0,  0, '0),
    mk(hne_pkg::CMD_LOAD,    0,  0, 15, '0),
    mk(hne_pkg::CMD_LOAD,    0,  0,  7, 64'h5555_5555_5555_5555),
    mk(hne_pkg::CMD_LOAD,   31, 15,  8, 64'h8000_0000_0000_0001),
    mk(hne_pkg::CMD_ENCODE,  0,  0,  0, '0),
    // repeated feature is counted twice
    mk(hne_pkg::CMD_ENCODE,  0,  0,  0, '0),
    mk(hne_pkg::CMD_ENCODE,  5,  5,  0, '0),
    // feature out of order closes the frame early
    mk(hne_pkg::CMD_ENCODE, 31, 15,  0, '0),
    mk(hne_pkg::CMD_ENCODE, 31, 15, 15, ONES),
    mk(hne_pkg::CMD_ENCODE, 16,  0,  0, ONES),
    mk(hne_pkg::CMD_ENCODE, 31, 15,  0, '0),
    // fourth frame completes the n-gram
    mk(hne_pkg::CMD_ENCODE, 31, 15,  0, '0),
    mk(hne_pkg::CMD_LOAD,   20,  4,  3, rand64()),
    mk(hne_pkg::CMD_ENCODE, 31, 15,  0, '0)
  };

  initial begin
    int next_feat;
    int roll;
    int feat;
    word_t w;
    mismatches   = 0;
    quiet_cycles = 0;
    frames_done  = 0;
    calm         = 0;
    hold_request = 0;
    running      = 0;
    foreach (ones_cnt[d]) ones_cnt[d] = 0;
    foreach (ngram_acc[s]) ngram_acc[s] = '0;
    foreach (item_written[l, f, s]) item_written[l][f][s] = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1;

    // Load one row for each feature in use
    foreach (used_feat[u]) begin
      for (int s = 0; s < NSL; s++) begin
        send_word(mk(hne_pkg::CMD_LOAD, used_feat[u], used_feat[u] % NLVL, s, rand64()));
      end
    end

    foreach (directed[i]) send_word(directed[i]);

    // Random part: full frames from the loaded features, some loads and strays
    hold_request = 1;
    next_feat = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 100 && i < 200);
      roll = $urandom_range(99);
      if (roll < 80) begin
        feat = (next_feat == NFEAT-1) ? NFEAT-1 : used_feat[$urandom_range(N_USED-2)];
        w = mk(hne_pkg::CMD_ENCODE, feat, pick_level(feat), $urandom_range(15),
               rand64());
        next_feat = (next_feat + 1) % NFEAT;
      end else if (roll < 95) begin
        feat = used_feat[$urandom_range(N_USED-1)];
        w = mk(hne_pkg::CMD_LOAD, feat, feat % NLVL, $urandom_range(15), rand64());
      end else begin
        feat = used_feat[$urandom_range(N_USED-1)];
        w = mk(hne_pkg::CMD_ENCODE, feat, pick_level(feat), $urandom_range(15),
               rand64());
      end
      send_word(w);
    end
    calm = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain the predicted slices, then let the pipeline settle
    while (hv_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && hv_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
